// ----- design/hdlcenc_pkg.sv -----
// Shared types, constants and the CRC step function for the HDLC frame encoder.
package hdlcenc_pkg;

   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_SEED  = 16'hFFFF;

   localparam int QUEUE_DEPTH_DEF = 4;

   // One queued job: the item as taken plus the finished frame check
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        frame_end;
      logic [15:0] crc_inv;
   } entry_type;

   // Head of the job queue as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // Byte position within one job
   typedef enum logic [1:0] {
      SLOT_DATA,
      SLOT_CRC_LO,
      SLOT_CRC_HI,
      SLOT_FLAG
   } slot_type;

   // Fold one byte into the reflected CRC-16, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- design/hdlcenc_req_if.sv -----
// Request channel: one raw payload beat with its frame markers.
interface hdlcenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output has_byte, output frame_end,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input frame_end,
                   output ready);
endinterface

// ----- design/hdlcenc_rsp_if.sv -----
// Response channel: one encoded line byte per beat.
interface hdlcenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_last;

   modport source (output valid, output out_byte, output frame_last, input ready);
   modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

// ----- design/hdlc_frame_encoder.sv -----
// HDLC frame encoder: byte stuffing with CRC-16 frame check and closing flag.
// The first line byte of an item passes through the job queue and then the output
//   register before it is valid on rsp.
// Throughput: one req beat per cycle while the job queue has room; the back end
//   sends one line byte per cycle while rsp is ready; an item yields 1 line byte, 2 if escaped,
//   and up to 7 when it closes a frame (data, CRC low, CRC high, each maybe escaped, flag).
// Reset: synchronous, active high; clears the queue, the output and seeds the CRC.
module hdlc_frame_encoder #(
   parameter int QUEUE_DEPTH = hdlcenc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   hdlcenc_req_if.sink   req_chan,
   hdlcenc_rsp_if.source rsp_chan
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   hdlcenc_pkg::entry_type q_entry;
   hdlcenc_pkg::head_type  q_head;

   hdlcenc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   hdlcenc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head       (q_head)
   );

   hdlcenc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- design/hdlcenc_front.sv -----
// Front end: accepts request beats, runs the CRC and queues encoding jobs.
module hdlcenc_front (
   input  logic                  clock,
   input  logic                  reset,
   hdlcenc_req_if.sink           req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output hdlcenc_pkg::entry_type q_entry
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] crc_upd;
   logic        take;

   assign req_chan.ready = !q_full;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      crc_upd = req_chan.has_byte ? hdlcenc_pkg::crc_fold(crc_ff, req_chan.data_byte) : crc_ff;
      crc_in  = crc_ff;
      if (take) begin
         crc_in = req_chan.frame_end ? hdlcenc_pkg::CRC_SEED : crc_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= hdlcenc_pkg::CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   // Drop beats that carry neither a byte nor an end marker
   assign q_push            = take && (req_chan.has_byte || req_chan.frame_end);
   assign q_entry.data_byte = req_chan.data_byte;
   assign q_entry.has_byte  = req_chan.has_byte;
   assign q_entry.frame_end = req_chan.frame_end;
   assign q_entry.crc_inv   = ~crc_upd;

   a_seed_after_end: assert property (@(posedge clock) disable iff (reset)
      take && req_chan.frame_end |=> crc_ff == hdlcenc_pkg::CRC_SEED)
      else $error("CRC not reseeded after frame end");

   a_idle_crc_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(crc_ff))
      else $error("CRC changed without an accepted beat");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed while the queue is full");

endmodule

// ----- design/hdlcenc_queue.sv -----
// Job queue between front and back end, flop based.
module hdlcenc_queue #(
   parameter int QUEUE_DEPTH = hdlcenc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hdlcenc_pkg::entry_type push_entry,
   input  logic                  pop,
   output logic                  full,
   output hdlcenc_pkg::head_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hdlcenc_pkg::entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ----- design/hdlcenc_back.sv -----
// Back end: expands queued jobs into stuffed line bytes, one per cycle while rsp is ready.
module hdlcenc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hdlcenc_pkg::head_type head,
   output logic                  pop,
   hdlcenc_rsp_if.source         rsp_chan
);

   hdlcenc_pkg::slot_type slot_ff, slot_in, slot_cur;
   logic       started_ff, started_in;
   logic       esc_ff, esc_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [7:0] byte_sel;
   logic       need_esc;
   logic       emit_go;

   assign emit_go = head.valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      slot_cur = started_ff ? slot_ff
               : (head.entry.has_byte ? hdlcenc_pkg::SLOT_DATA : hdlcenc_pkg::SLOT_CRC_LO);
      case (slot_cur)
         hdlcenc_pkg::SLOT_DATA:   byte_sel = head.entry.data_byte;
         hdlcenc_pkg::SLOT_CRC_LO: byte_sel = head.entry.crc_inv[7:0];
         hdlcenc_pkg::SLOT_CRC_HI: byte_sel = head.entry.crc_inv[15:8];
         hdlcenc_pkg::SLOT_FLAG:   byte_sel = hdlcenc_pkg::FLAG_BYTE;
         default:                  byte_sel = hdlcenc_pkg::FLAG_BYTE;
      endcase
      need_esc = (slot_cur != hdlcenc_pkg::SLOT_FLAG) &&
                 (byte_sel == hdlcenc_pkg::ESC_BYTE || byte_sel == hdlcenc_pkg::FLAG_BYTE);

      slot_in    = slot_ff;
      started_in = started_ff;
      esc_in     = esc_ff;
      pop        = 1'b0;
      byte_in    = byte_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_chan.ready;

      if (emit_go) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         if (need_esc && !esc_ff) begin
            // Send the escape, hold the slot for the flipped byte
            byte_in    = hdlcenc_pkg::ESC_BYTE;
            esc_in     = 1'b1;
            started_in = 1'b1;
            slot_in    = slot_cur;
         end else begin
            byte_in = esc_ff ? (byte_sel ^ hdlcenc_pkg::ESC_XOR) : byte_sel;
            last_in = (slot_cur == hdlcenc_pkg::SLOT_FLAG);
            esc_in  = 1'b0;
            if (slot_cur == hdlcenc_pkg::SLOT_FLAG ||
                (slot_cur == hdlcenc_pkg::SLOT_DATA && !head.entry.frame_end)) begin
               pop        = 1'b1;
               started_in = 1'b0;
               slot_in    = hdlcenc_pkg::SLOT_DATA;
            end else begin
               started_in = 1'b1;
               case (slot_cur)
                  hdlcenc_pkg::SLOT_DATA:   slot_in = hdlcenc_pkg::SLOT_CRC_LO;
                  hdlcenc_pkg::SLOT_CRC_LO: slot_in = hdlcenc_pkg::SLOT_CRC_HI;
                  hdlcenc_pkg::SLOT_CRC_HI: slot_in = hdlcenc_pkg::SLOT_FLAG;
                  default:                  slot_in = hdlcenc_pkg::SLOT_DATA;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= hdlcenc_pkg::SLOT_DATA;
         started_ff <= 1'b0;
         esc_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         slot_ff    <= slot_in;
         started_ff <= started_in;
         esc_ff     <= esc_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_byte   = byte_ff;
   assign rsp_chan.frame_last = last_ff;

   a_last_is_flag: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> byte_ff == hdlcenc_pkg::FLAG_BYTE)
      else $error("frame_last on a byte other than the flag");

   a_esc_has_job: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> head.valid && started_ff)
      else $error("pending escape without a job");

   a_esc_precedes: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> byte_ff == hdlcenc_pkg::ESC_BYTE && valid_ff)
      else $error("escape state without an escape byte sent");

endmodule

// ----- dv/hdlc_frame_encoder_tb.sv -----
// Testbench for hdlc_frame_encoder: directed and random framed bytes checked against a stuffing/FCS predictor.
`timescale 1ns / 100ps

module hdlc_frame_encoder_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct {
      logic [7:0] octet;
      logic       last;
   } line_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdlcenc_req_if req_bus ();
   hdlcenc_rsp_if rsp_bus ();

   hdlc_frame_encoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   req_item_type  req_pending[$];
   line_beat_type line_expect[$];
   req_item_type  req_current;
   line_beat_type line_seen;
   line_beat_type line_want;
   logic       req_offered = 1'b0;
   logic       rx_hold = 1'b0;
   logic [15:0] fcs_state = hdlcenc_pkg::CRC_SEED;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Reflected CRC-16, one bit per step: feedback is the bit shifted out XORed with the data bit
   function automatic logic [15:0] fcs_update(logic [15:0] fcs, logic [7:0] octet);
      logic [15:0] acc;
      logic        fb;
      acc = fcs;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ octet[i];
         acc = {1'b0, acc[15:1]};
         if (fb) begin
            acc = acc ^ hdlcenc_pkg::CRC_POLY;
         end
      end
      return acc;
   endfunction

   function automatic void push_line(logic [7:0] octet, logic last);
      line_beat_type lb;
      lb.octet = octet;
      lb.last  = last;
      line_expect.push_back(lb);
   endfunction

   function automatic void push_stuffed(logic [7:0] octet);
      if (octet == hdlcenc_pkg::ESC_BYTE || octet == hdlcenc_pkg::FLAG_BYTE) begin
         push_line(hdlcenc_pkg::ESC_BYTE, 1'b0);
         push_line(octet ^ hdlcenc_pkg::ESC_XOR, 1'b0);
      end else begin
         push_line(octet, 1'b0);
      end
   endfunction

   // Expected line bytes for one accepted request beat
   function automatic void encode_item(req_item_type it);
      logic [15:0] fcs_inv;
      if (it.has_byte) begin
         fcs_state = fcs_update(fcs_state, it.data_byte);
         push_stuffed(it.data_byte);
      end
      if (it.frame_end) begin
         fcs_inv = ~fcs_state;
         push_stuffed(fcs_inv[7:0]);
         push_stuffed(fcs_inv[15:8]);
         push_line(hdlcenc_pkg::FLAG_BYTE, 1'b1);
         fcs_state = hdlcenc_pkg::CRC_SEED;
      end
   endfunction

   function automatic void push_item(logic [7:0] data_byte, logic has_byte, logic frame_end);
      req_item_type it;
      it.data_byte = data_byte;
      it.has_byte  = has_byte;
      it.frame_end = frame_end;
      req_pending.push_back(it);
   endfunction

   function automatic logic [7:0] pick_octet();
      if ($urandom_range(3) == 0) begin
         return $urandom_range(1) ? hdlcenc_pkg::FLAG_BYTE : hdlcenc_pkg::ESC_BYTE;
      end
      return 8'($urandom_range(255));
   endfunction

   // Whole frames with random content; idle beats in between do not count
   function automatic void add_random_frames(int n_items);
      int added;
      int frame_len;
      added = 0;
      while (added < n_items) begin
         frame_len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(8);
         for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(7) == 0) begin
               push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            push_item(pick_octet(), 1'b1,
                      (i == frame_len - 1) && $urandom_range(1));
            added++;
         end
         // close with a bare marker unless the last byte already did
         if (frame_len == 0 || !req_pending[$].frame_end) begin
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
            added++;
         end
      end
   endfunction

   task automatic wait_line_drained();
      while (req_pending.size() != 0 || req_offered || line_expect.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            encode_item(req_current);
            req_offered = 1'b0;
         end
         if (!req_offered && req_pending.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_current = req_pending.pop_front();
            req_offered = 1'b1;
            req_bus.data_byte <= req_current.data_byte;
            req_bus.has_byte  <= req_current.has_byte;
            req_bus.frame_end <= req_current.frame_end;
            req_bus.valid     <= 1'b1;
         end else if (!req_offered) begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Line monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            line_seen.octet = rsp_bus.out_byte;
            line_seen.last  = rsp_bus.frame_last;
            if (line_expect.size() == 0) begin
               $display("%0t: unexpected line beat %02h last=%0b", $time,
                        line_seen.octet, line_seen.last);
               error_count++;
            end else begin
               line_want = line_expect.pop_front();
               if (line_seen.octet !== line_want.octet) begin
                  $display("%0t: out_byte mismatch: expected %02h, got %02h", $time,
                           line_want.octet, line_seen.octet);
                  error_count++;
               end
               if (line_seen.last !== line_want.last) begin
                  $display("%0t: frame_last mismatch: expected %0b, got %0b", $time,
                           line_want.last, line_seen.last);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [15:0] fcs_inv;
      logic        found_lo;
      logic        found_hi;
      logic [7:0]  lo_a, lo_b, hi_a, hi_b;

      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.has_byte  = 1'b0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready     = 1'b0;

      // find two-byte frames whose inverted FCS needs stuffing in the low byte, and in the high byte
      found_lo = 1'b0;
      found_hi = 1'b0;
      for (int a = 0; a < 256; a++) begin
         for (int b = 0; b < 256; b++) begin
            fcs_inv = ~fcs_update(fcs_update(hdlcenc_pkg::CRC_SEED, 8'(a)), 8'(b));
            if (!found_lo && (fcs_inv[7:0] == hdlcenc_pkg::ESC_BYTE ||
                              fcs_inv[7:0] == hdlcenc_pkg::FLAG_BYTE)) begin
               found_lo = 1'b1;
               lo_a = 8'(a);
               lo_b = 8'(b);
            end
            if (!found_hi && (fcs_inv[15:8] == hdlcenc_pkg::ESC_BYTE ||
                              fcs_inv[15:8] == hdlcenc_pkg::FLAG_BYTE)) begin
               found_hi = 1'b1;
               hi_a = 8'(a);
               hi_b = 8'(b);
            end
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed frames, no idling
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h7D, 1'b1, 1'b0);
      push_item(8'h7E, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h5D, 1'b1, 1'b0);
      push_item(8'h5E, 1'b1, 1'b0);
      push_item(8'h7C, 1'b1, 1'b0);
      push_item(8'h7F, 1'b1, 1'b1);
      push_item(8'h7E, 1'b1, 1'b1);
      push_item(8'h7D, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      if (found_lo) begin
         push_item(lo_a, 1'b1, 1'b0);
         push_item(lo_b, 1'b1, 1'b1);
      end
      if (found_hi) begin
         push_item(hi_a, 1'b1, 1'b0);
         push_item(hi_b, 1'b1, 1'b1);
      end
      push_item(8'hAA, 1'b0, 1'b1);
      push_item(8'h55, 1'b0, 1'b1);
      push_item(8'h55, 1'b1, 1'b0);
      push_item(8'hAA, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      wait_line_drained();

      add_random_frames(65);
      wait_line_drained();

      send_idle_pct = 79;
      add_random_frames(65);
      wait_line_drained();

      send_idle_pct = 0;
      stall_pct = 79;
      add_random_frames(65);
      wait_line_drained();

      send_idle_pct = 8;
      stall_pct = 8;
      add_random_frames(65);
      wait_line_drained();

      // hold the receiver off so the job queue fills and stalls the input
      send_idle_pct = 0;
      stall_pct = 0;
      add_random_frames(30);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
      wait_line_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && line_expect.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
